>>> rtl/core/scba_pkg.sv
// ----------------------------------------------------------------------------
// scba_pkg
// shared constants, codes and class tables for the size-class block allocator
// ----------------------------------------------------------------------------
`default_nettype none
package scba_pkg;
  localparam int POOL_PAGES  = 16;
  localparam int NUM_CLASSES = 8;
  localparam int PW          = $clog2(POOL_PAGES);   // page number width
  localparam int LW          = PW + 1;               // page link incl. null
  localparam int BW          = 7;                    // block index width
  localparam int CW          = 3;                    // class width
  localparam int TW          = 11;                   // class total width
  localparam int AW          = PW + BW;              // block link address
  localparam logic [LW-1:0] NULL_PAGE = LW'(POOL_PAGES);
  localparam logic [12:0] MAX_BLOCK_BYTES = 13'd4072;
  localparam logic [BW-1:0] END_LINK = 7'h7f;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_TOO_BIG = 2'd1;
  localparam logic [1:0] ST_NO_PAGE = 2'd2;
  localparam logic [1:0] ST_BAD_FREE = 2'd3;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  function automatic logic [BW-1:0] class_blocks(input logic [CW-1:0] c);
    case (c)
      3'd0: class_blocks = 7'd102;
      3'd1: class_blocks = 7'd56;
      3'd2: class_blocks = 7'd30;
      3'd3: class_blocks = 7'd15;
      3'd4: class_blocks = 7'd7;
      3'd5: class_blocks = 7'd4;
      3'd6: class_blocks = 7'd2;
      default: class_blocks = 7'd1;
    endcase
  endfunction

  function automatic logic [CW-1:0] size_to_class(input logic [12:0] s);
    if (s <= 13'd32) size_to_class = 3'd0;
    else if (s <= 13'd64) size_to_class = 3'd1;
    else if (s <= 13'd128) size_to_class = 3'd2;
    else if (s <= 13'd256) size_to_class = 3'd3;
    else if (s <= 13'd512) size_to_class = 3'd4;
    else if (s <= 13'd1012) size_to_class = 3'd5;
    else if (s <= 13'd2032) size_to_class = 3'd6;
    else size_to_class = 3'd7;
  endfunction
endpackage
`default_nettype wire

>>> rtl/core/size_class_block_allocator.sv
// ----------------------------------------------------------------------------
// size_class_block_allocator
// size-class block allocator over a pool of 4 KiB pages
// ----------------------------------------------------------------------------
// one item is taken at a time and answered with exactly one result item. the
// per-block free links live in a 2048-entry synchronous memory with a
// registered read; page and class bookkeeping sit in small register files. an
// allocate from a partial page goes through head lookup, link read, write
// back and result; an allocate that claims a fresh page first sweeps its
// block links, one per cycle, n of them with n the class block count (at
// most 102). a free pushes the block onto its page's free list and, when the
// page becomes fully free, walks the class list (at most 16 pages) to unlink
// it. the result sits in an output register, and the next item is taken
// once it has been handed over.
// status: 0 ok, 1 request too large, 2 pool exhausted, 3 free rejected.
`default_nettype none
module size_class_block_allocator (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [23:0] in_tdata,   // req_size[12:0], free_page_num[16:13],
                                  // free_block_idx[23:17]
  input  wire         in_tuser,   // op
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [23:0] out_tdata   // status[1:0], page_num[5:2], block_idx[12:6],
                                  // size_class[15:13], page_released[16], zero
);
  import scba_pkg::*;

  // state codes
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_INIT  = 3'd1;
  localparam logic [2:0] S_ARD   = 3'd2;
  localparam logic [2:0] S_AWB   = 3'd3;
  localparam logic [2:0] S_WALK  = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0] state_r, state_nxt;

  // input field split
  logic          f_op;
  logic [12:0]   f_size;
  logic [PW-1:0] f_page;
  logic [BW-1:0] f_blk;
  assign f_op   = in_tuser;
  assign f_size = in_tdata[12:0];
  assign f_page = in_tdata[16:13];
  assign f_blk  = in_tdata[23:17];

  // page and class tables
  logic [POOL_PAGES-1:0] page_busy_r;
  logic [CW-1:0] page_class_r [POOL_PAGES];
  logic [BW-1:0] page_cnt_r   [POOL_PAGES];
  logic [BW-1:0] page_head_r  [POOL_PAGES];
  logic [LW-1:0] page_link_r  [POOL_PAGES];
  logic [LW-1:0] class_head_r [NUM_CLASSES];
  logic [TW-1:0] class_tot_r  [NUM_CLASSES];

  // block link memory
  logic [BW-1:0] blk_mem [POOL_PAGES*128];
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [BW-1:0] mem_wdata, mem_rdata_r;

  always_ff @(posedge clk) begin
    if (mem_we) blk_mem[mem_waddr] <= mem_wdata;
    mem_rdata_r <= blk_mem[mem_raddr];
  end

  // working registers
  logic [CW-1:0] cls_r;
  logic [PW-1:0] pg_r;
  logic [BW-1:0] blk_r, cnt_r;
  logic [LW-1:0] cur_r, prev_r;
  logic [4:0]    steps_r;
  logic [1:0]    o_status_r;
  logic [PW-1:0] o_page_r;
  logic [BW-1:0] o_blk_r;
  logic [CW-1:0] o_cls_r;
  logic          o_rel_r;

  // lowest free page search
  logic          any_free;
  logic [PW-1:0] free_pg;
  always_comb begin
    any_free = 1'b0;
    free_pg  = '0;
    for (int i = POOL_PAGES - 1; i >= 0; i--) begin
      if (!page_busy_r[i]) begin
        any_free = 1'b1;
        free_pg  = PW'(i);
      end
    end
  end

  logic [CW-1:0] req_cls;
  assign req_cls = size_to_class(f_size);

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = {7'd0, o_rel_r, o_cls_r, o_blk_r, o_page_r, o_status_r};

  logic [BW-1:0] fr_cnt_inc;
  logic [BW-1:0] fr_n;
  logic [CW-1:0] fr_cls;
  logic          fr_ok;
  assign fr_cls     = page_class_r[f_page];
  assign fr_n       = class_blocks(fr_cls);
  assign fr_cnt_inc = page_cnt_r[f_page] + 7'd1;
  assign fr_ok      = page_busy_r[f_page] && (f_blk < fr_n);

  always_comb begin
    state_nxt = state_r;
    mem_we    = 1'b0;
    mem_waddr = {pg_r, blk_r};
    mem_wdata = '0;
    mem_raddr = {pg_r, page_head_r[pg_r]};
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (f_op == OP_FREE) begin
            if (fr_ok) begin
              mem_we    = 1'b1;
              mem_waddr = {f_page, f_blk};
              mem_wdata = page_head_r[f_page];
              state_nxt = (fr_cnt_inc >= fr_n) ? S_WALK : S_OUT;
            end else begin
              state_nxt = S_OUT;
            end
          end else if (f_size > MAX_BLOCK_BYTES) begin
            state_nxt = S_OUT;
          end else if (class_head_r[req_cls] != NULL_PAGE) begin
            state_nxt = S_ARD;
          end else if (any_free) begin
            state_nxt = S_INIT;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_INIT: begin
        // link blocks 0..n-1 of the fresh page
        mem_we    = 1'b1;
        mem_waddr = {pg_r, blk_r};
        mem_wdata = (blk_r + 7'd1 < cnt_r) ? blk_r + 7'd1 : END_LINK;
        if (blk_r + 7'd1 >= cnt_r) state_nxt = S_ARD;
      end
      S_ARD: state_nxt = S_AWB;
      S_AWB: state_nxt = S_OUT;
      S_WALK: begin
        if (cur_r == {1'b0, pg_r} || cur_r == NULL_PAGE || steps_r == 5'(POOL_PAGES - 1))
          state_nxt = S_OUT;
      end
      S_OUT: if (out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      page_busy_r <= '0;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        class_head_r[i] <= NULL_PAGE;
        class_tot_r[i]  <= '0;
      end
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_IDLE: if (in_tvalid) begin
          steps_r <= '0;
          if (f_op == OP_FREE) begin
            if (fr_ok) begin
              page_head_r[f_page] <= f_blk;
              page_cnt_r[f_page]  <= fr_cnt_inc;
              o_status_r <= ST_OK;
              o_page_r   <= f_page;
              o_blk_r    <= f_blk;
              o_cls_r    <= fr_cls;
              pg_r       <= f_page;
              cls_r      <= fr_cls;
              cur_r      <= class_head_r[fr_cls];
              prev_r     <= NULL_PAGE;
              if (fr_cnt_inc >= fr_n) begin
                page_busy_r[f_page] <= 1'b0;
                class_tot_r[fr_cls] <= class_tot_r[fr_cls] + 11'd1 - TW'(fr_n);
                o_rel_r <= 1'b1;
              end else begin
                class_tot_r[fr_cls] <= class_tot_r[fr_cls] + 11'd1;
                o_rel_r <= 1'b0;
                if (fr_cnt_inc == 7'd1) begin
                  // page was full, put it back at the head of its class list
                  page_link_r[f_page]  <= class_head_r[fr_cls];
                  class_head_r[fr_cls] <= {1'b0, f_page};
                end
              end
            end else begin
              o_status_r <= ST_BAD_FREE;
              o_page_r   <= '0;
              o_blk_r    <= '0;
              o_cls_r    <= '0;
              o_rel_r    <= 1'b0;
            end
          end else if (f_size > MAX_BLOCK_BYTES) begin
            o_status_r <= ST_TOO_BIG;
            o_page_r   <= '0;
            o_blk_r    <= '0;
            o_cls_r    <= '0;
            o_rel_r    <= 1'b0;
          end else begin
            cls_r    <= req_cls;
            o_cls_r  <= req_cls;
            o_page_r <= '0;
            o_blk_r  <= '0;
            o_rel_r  <= 1'b0;
            if (class_head_r[req_cls] != NULL_PAGE) begin
              o_status_r <= ST_OK;
              pg_r       <= class_head_r[req_cls][PW-1:0];
            end else if (any_free) begin
              o_status_r <= ST_OK;
              pg_r    <= free_pg;
              blk_r   <= '0;
              cnt_r   <= class_blocks(req_cls);
              page_busy_r[free_pg]  <= 1'b1;
              page_class_r[free_pg] <= req_cls;
              page_cnt_r[free_pg]   <= class_blocks(req_cls);
              page_head_r[free_pg]  <= '0;
              page_link_r[free_pg]  <= NULL_PAGE;
              class_head_r[req_cls] <= {1'b0, free_pg};
              class_tot_r[req_cls]  <= class_tot_r[req_cls] + TW'(class_blocks(req_cls));
            end else begin
              o_status_r <= ST_NO_PAGE;
            end
          end
        end
        S_INIT: blk_r <= blk_r + 7'd1;
        S_ARD: ;  // link of the head block is being read
        S_AWB: begin
          o_page_r <= pg_r;
          o_blk_r  <= page_head_r[pg_r];
          page_head_r[pg_r] <= mem_rdata_r;
          page_cnt_r[pg_r]  <= page_cnt_r[pg_r] - 7'd1;
          class_tot_r[cls_r] <= class_tot_r[cls_r] - 11'd1;
          if (page_cnt_r[pg_r] == 7'd1) class_head_r[cls_r] <= page_link_r[pg_r];
        end
        S_WALK: begin
          steps_r <= steps_r + 5'd1;
          if (cur_r == {1'b0, pg_r}) begin
            if (prev_r == NULL_PAGE) class_head_r[cls_r] <= page_link_r[pg_r];
            else page_link_r[prev_r[PW-1:0]] <= page_link_r[pg_r];
          end else if (cur_r != NULL_PAGE) begin
            prev_r <= cur_r;
            cur_r  <= page_link_r[cur_r[PW-1:0]];
          end
        end
        default: ;
      endcase
    end
  end

  // checks
  a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready) else $error("item taken twice");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("result changed while stalled");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid)) else $error("accept while result pending");
endmodule
`default_nettype wire

>>> tb/sv/scba_checker.sv
// ----------------------------------------------------------------------------
// scba_checker
// watches both channels of the allocator, predicts each result and compares
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module scba_checker (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  input  wire         in_tready,
  input  wire  [23:0] in_tdata,
  input  wire         in_tuser,
  input  wire         out_tvalid,
  input  wire         out_tready,
  input  wire  [23:0] out_tdata,
  output int          fail_count,
  output int          pending
);
  import scba_pkg::*;

  // highest bit first, so status lands in the lowest bits
  typedef struct packed {
    logic       rel;
    logic [2:0] cls;
    logic [6:0] blk;
    logic [3:0] page;
    logic [1:0] status;
  } alloc_res_t;

  localparam logic [12:0] CLASS_SIZE [8] =
    '{13'd32, 13'd64, 13'd128, 13'd256, 13'd512, 13'd1012, 13'd2032, 13'd4072};
  localparam logic [6:0] CLASS_COUNT [8] =
    '{7'd102, 7'd56, 7'd30, 7'd15, 7'd7, 7'd4, 7'd2, 7'd1};

  // shadow of the allocator state
  logic       pg_busy [16];
  logic [2:0] pg_cls  [16];
  logic [6:0] pg_cnt  [16];
  logic [6:0] pg_head [16];
  logic [4:0] pg_next [16];
  logic [6:0] blk_next [2048];
  logic [4:0] cls_head [8];

  alloc_res_t expected_q[$];

  task automatic unlink_page(input logic [2:0] c, input logic [3:0] p);
    logic [4:0] cur;
    logic [4:0] prev;
    cur = cls_head[c];
    prev = NULL_PAGE;
    for (int s = 0; s < 16 && cur < 16; s++) begin
      if (cur == {1'b0, p}) begin
        if (prev == NULL_PAGE) cls_head[c] = pg_next[cur];
        else pg_next[prev] = pg_next[cur];
        return;
      end
      prev = cur;
      cur = pg_next[cur];
    end
  endtask

  task automatic predict_alloc_result(input logic op, input logic [12:0] size,
                                      input logic [3:0] fp, input logic [6:0] fb,
                                      output alloc_res_t r);
    logic [2:0] c;
    logic [6:0] n;
    int p;
    logic [6:0] b;
    r = '0;
    if (op == OP_ALLOC) begin
      if (size > MAX_BLOCK_BYTES) begin
        r.status = ST_TOO_BIG;
        return;
      end
      c = 3'd7;
      for (int k = 6; k >= 0; k--) if (size <= CLASS_SIZE[k]) c = 3'(k);
      n = CLASS_COUNT[c];
      if (cls_head[c] >= 16) begin
        p = 0;
        while (p < 16 && pg_busy[p]) p++;
        if (p >= 16) begin
          r.status = ST_NO_PAGE;
          r.cls = c;
          return;
        end
        // claim a fresh page and chain its blocks in order
        pg_busy[p] = 1'b1;
        pg_cls[p] = c;
        pg_cnt[p] = n;
        pg_head[p] = '0;
        for (int i = 0; i < n; i++)
          blk_next[p * 128 + i] = (i + 1 < n) ? 7'(i + 1) : END_LINK;
        pg_next[p] = cls_head[c];
        cls_head[c] = 5'(p);
      end
      p = cls_head[c];
      b = pg_head[p];
      pg_head[p] = blk_next[p * 128 + b];
      pg_cnt[p] = pg_cnt[p] - 7'd1;
      if (pg_cnt[p] == 0) cls_head[c] = pg_next[p];
      r.page = 4'(p);
      r.blk = b;
      r.cls = c;
      return;
    end
    if (!pg_busy[fp]) begin
      r.status = ST_BAD_FREE;
      return;
    end
    c = pg_cls[fp];
    n = CLASS_COUNT[c];
    if (fb >= n) begin
      r.status = ST_BAD_FREE;
      return;
    end
    blk_next[fp * 128 + fb] = pg_head[fp];
    pg_head[fp] = fb;
    pg_cnt[fp] = pg_cnt[fp] + 7'd1;
    r.page = fp;
    r.blk = fb;
    r.cls = c;
    if (pg_cnt[fp] >= n) begin
      unlink_page(c, fp);
      pg_busy[fp] = 1'b0;
      r.rel = 1'b1;
    end else if (pg_cnt[fp] == 1) begin
      pg_next[fp] = cls_head[c];
      cls_head[c] = {1'b0, fp};
    end
  endtask

  assign pending = expected_q.size();

  always @(posedge clk) begin
    alloc_res_t exp_r;
    alloc_res_t got;
    if (!rst_n) begin
      fail_count <= 0;
      expected_q.delete();
      for (int i = 0; i < 16; i++) pg_busy[i] = 1'b0;
      for (int i = 0; i < 8; i++) cls_head[i] = NULL_PAGE;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[16:0];
        if (expected_q.size() == 0) begin
          $error("result item with nothing expected: %h", out_tdata);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if (got !== exp_r) begin
            fail_count <= fail_count + 1;
            if (got.status !== exp_r.status)
              $error("status: expected %0d actual %0d", exp_r.status, got.status);
            if (got.page !== exp_r.page)
              $error("page_num: expected %0d actual %0d", exp_r.page, got.page);
            if (got.blk !== exp_r.blk)
              $error("block_idx: expected %0d actual %0d", exp_r.blk, got.blk);
            if (got.cls !== exp_r.cls)
              $error("size_class: expected %0d actual %0d", exp_r.cls, got.cls);
            if (got.rel !== exp_r.rel)
              $error("page_released: expected %0d actual %0d", exp_r.rel, got.rel);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        predict_alloc_result(in_tuser, in_tdata[12:0], in_tdata[16:13],
                             in_tdata[23:17], exp_r);
        expected_q.push_back(exp_r);
      end
    end
  end
endmodule

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the size-class block allocator
// ----------------------------------------------------------------------------
// directed allocations at every class boundary and the error cases, then
// random traffic that frees blocks it has been given, allocates and sends noise, with pool floods
`timescale 1ns / 1ps
module tb;
  import scba_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // req_size, free_page_num, free_block_idx
  logic        in_tuser;   // op
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // status, page_num, block_idx, size_class, page_released
  int          fail_count;
  int          pending;

  // blocks handed out and not yet given back, as {page, block}
  logic [10:0] live_blocks[$];
  logic        sent_ops[$];
  int          burst_left;
  int          cyc = 0;

  size_class_block_allocator i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  scba_checker i_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // learn which blocks were handed out, to free them later
  always @(posedge clk) begin
    logic op;
    if (rst_n) begin
      if (in_tvalid && in_tready) sent_ops.push_back(in_tuser);
      if (out_tvalid && out_tready && sent_ops.size() > 0) begin
        op = sent_ops.pop_front();
        if (op == OP_ALLOC && out_tdata[1:0] == ST_OK)
          live_blocks.push_back({out_tdata[5:2], out_tdata[12:6]});
      end
    end
  end

  // receiver: stall pattern steps through three modes in turn, plus one long hold-off
  always @(negedge clk) begin
    int mode;
    cyc <= cyc + 1;
    mode = (cyc / 200) % 3;
    if (cyc >= 3000 && cyc < 3500) out_tready <= 1'b0;
    else if (mode == 0) out_tready <= 1'b1;
    else if (mode == 1) out_tready <= ($urandom_range(0, 3) != 0);
    else out_tready <= ($urandom_range(0, 3) == 0);
  end

  // one item, held until accepted; bursts with random gaps in between
  task automatic send_item(input logic op, input logic [12:0] size,
                           input logic [3:0] fp, input logic [6:0] fb);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {fb, fp, size};
    in_tuser <= op;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    burst_left--;
  endtask

  task automatic free_live_block();
    int k;
    logic [10:0] pb;
    k = $urandom_range(0, live_blocks.size() - 1);
    pb = live_blocks[k];
    live_blocks.delete(k);
    send_item(OP_FREE, 13'($urandom), pb[10:7], pb[6:0]);
  endtask

  task automatic send_random_item();
    int sel;
    logic [12:0] size;
    sel = $urandom_range(0, 99);
    if (sel < 45 && live_blocks.size() > 0) begin
      free_live_block();
    end else if (sel < 55) begin
      // noise: any page, any index, any size bits
      send_item(1'($urandom), 13'($urandom), 4'($urandom), 7'($urandom));
    end else begin
      case ($urandom_range(0, 9))
        0: size = 13'($urandom_range(4073, 8191));
        1: size = 13'($urandom_range(2033, 4072));
        2: size = 13'($urandom_range(1013, 2032));
        3: size = 13'($urandom_range(513, 1012));
        4: size = 13'($urandom_range(257, 512));
        5: size = 13'($urandom_range(129, 256));
        6: size = 13'($urandom_range(65, 128));
        7: size = 13'($urandom_range(33, 64));
        default: size = 13'($urandom_range(0, 32));
      endcase
      send_item(OP_ALLOC, size, 4'($urandom), 7'($urandom));
    end
  endtask

  initial begin
    logic [12:0] edges [19] = '{13'd0, 13'd1, 13'd32, 13'd33, 13'd64, 13'd65, 13'd128,
                               13'd129, 13'd256, 13'd257, 13'd512, 13'd513, 13'd1012,
                               13'd1013, 13'd2032, 13'd2033, 13'd4072, 13'd4073,
                               13'd8191};
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    burst_left = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // every class boundary and both oversize extremes
    foreach (edges[i]) send_item(OP_ALLOC, edges[i], 4'd0, 7'd0);
    // page not in use, index beyond the class count, double free
    send_item(OP_FREE, 13'd0, 4'd15, 7'd0);
    send_item(OP_FREE, 13'd0, 4'd7, 7'd1);
    send_item(OP_FREE, 13'd0, 4'd0, 7'd127);
    send_item(OP_FREE, 13'd0, 4'd0, 7'd1);
    send_item(OP_FREE, 13'd0, 4'd0, 7'd1);

    for (int n = 0; n < 1800; n++) begin
      // flood the pool with whole-page blocks now and then, and let the results drain
      if (n % 300 == 150) begin
        repeat (18) send_item(OP_ALLOC, 13'($urandom_range(2033, 4072)), 4'd0, 7'd0);
        while (sent_ops.size() > 0) @(negedge clk);
      end
      send_random_item();
    end
    in_tvalid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (fail_count == 0) $display("PASS size_class_block_allocator");
    else $display("FAIL size_class_block_allocator");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL size_class_block_allocator");
    $finish;
  end
endmodule
